/* design/fic_pkg.sv */
// Package for the fuzzy inference controller: set geometry, rule table,
// payload and fuzzifier/defuzzifier helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fic_pkg;

  localparam int unsigned NUM_SETS   = 7;
  localparam int unsigned NUM_RULES  = 15;
  localparam int unsigned FULL_SCALE = 255;

  localparam int unsigned AREA_W = 14;  // trapezoid area bound 255 * 128 / 2 = 16320
  localparam int unsigned PROD_W = 22;  // area times centroid
  localparam int unsigned SUMP_W = 25;  // sum of seven products
  localparam int unsigned SUMA_W = 17;  // sum of seven areas
  localparam int unsigned QUOT_W = 8;   // quotient bits, mean centroid < 256

  // Triangle end points, slopes and centroids (step of 32 on a 0..255 scale)
  localparam int unsigned SET_LEFT  [NUM_SETS] = '{0, 31, 63, 95, 127, 159, 191};
  localparam int unsigned SET_RIGHT [NUM_SETS] = '{63, 95, 127, 159, 191, 223, 255};
  localparam int unsigned SLOPE_L   [NUM_SETS] = '{8, 7, 7, 7, 7, 7, 7};
  localparam int unsigned SLOPE_R   [NUM_SETS] = '{7, 7, 7, 7, 7, 7, 7};
  localparam int unsigned SET_CTR   [NUM_SETS] = '{31, 63, 95, 127, 159, 191, 223};

  typedef struct packed {
    logic [3:0] ia;
    logic [3:0] iv;
    logic [3:0] io;
  } rule_t;

  // angle set, velocity set, force set
  localparam rule_t RULES [NUM_RULES] = '{
    '{4'd0, 4'd3, 4'd6}, '{4'd3, 4'd0, 4'd6}, '{4'd1, 4'd3, 4'd5},
    '{4'd3, 4'd1, 4'd5}, '{4'd2, 4'd3, 4'd4}, '{4'd3, 4'd2, 4'd4},
    '{4'd2, 4'd4, 4'd4}, '{4'd3, 4'd3, 4'd3}, '{4'd3, 4'd4, 4'd2},
    '{4'd4, 4'd3, 4'd2}, '{4'd4, 4'd2, 4'd2}, '{4'd3, 4'd5, 4'd1},
    '{4'd1, 4'd3, 4'd1}, '{4'd3, 4'd6, 4'd0}, '{4'd6, 4'd3, 4'd0}
  };

  typedef struct packed {
    logic [7:0] angle;
    logic [7:0] velocity;
  } fic_in_t;

  typedef struct packed {
    logic [7:0] force_res;
    logic       no_rule_fired;
  } fic_out_t;

  // v / 7 for v < 256 by reciprocal multiply
  function automatic logic [7:0] div7(logic [7:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd293;
    return p[18:11];
  endfunction

  // v / slope for the slopes in use (8 or 7)
  function automatic logic [7:0] div_slope(logic [7:0] v, int unsigned s);
    logic [7:0] q;
    if (s == 8) q = v >> 3;
    else        q = div7(v);
    return q;
  endfunction

  // Membership degree of x in set j
  function automatic logic [7:0] fz_degree(int unsigned j, logic [7:0] x);
    logic signed [9:0] d1;
    logic signed [9:0] d2;
    logic [12:0] a;
    logic [12:0] b;
    logic [12:0] m;
    logic [7:0]  r;
    d1 = $signed({2'b00, x}) - $signed(10'(SET_LEFT[j]));
    d2 = $signed(10'(SET_RIGHT[j])) - $signed({2'b00, x});
    a  = 13'(SLOPE_L[j]) * 13'(d1[8:0]);
    b  = 13'(SLOPE_R[j]) * 13'(d2[8:0]);
    m  = (b < a) ? b : a;
    if (d1 <= 0 || d2 <= 0)      r = '0;
    else if (m > 13'(FULL_SCALE)) r = 8'(FULL_SCALE);
    else                         r = m[7:0];
    return r;
  endfunction

  // Clipped trapezoid area of output set j at strength v
  function automatic logic [AREA_W-1:0] fz_area(int unsigned j, logic [7:0] v);
    logic signed [10:0] tot;
    logic [18:0]        p;
    logic [AREA_W-1:0]  r;
    tot = $signed(11'(2 * (SET_RIGHT[j] - SET_LEFT[j])))
          - $signed({3'b000, div_slope(v, SLOPE_L[j])})
          - $signed({3'b000, div_slope(v, SLOPE_R[j])});
    p = 19'(v) * 19'(tot[9:0]);
    if (tot <= 0) r = '0;
    else          r = p[AREA_W:1];
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/fuzzy_inference_controller_core.sv */
// Fuzzy inference controller: one item per cycle sustained while the output is not stalled.
// Stages: fuzzify, rule min/max, areas, centroid products, sums, then an
// eight-stage restoring divider (one quotient bit per stage); the last
// divider stage is the output register. Each stage holds its own valid bit and
// fills bubbles while the output is stalled. Reset clears all valid bits.
// Uses fic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_inference_controller_core
  import fic_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire fic_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output fic_out_t      out_data
);

  localparam int unsigned NSTG = 5 + QUOT_W;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // Per-stage ready: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: fuzzify both inputs
  logic [7:0] mu_a_r [NUM_SETS];
  logic [7:0] mu_v_r [NUM_SETS];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < NUM_SETS; j++) begin
        mu_a_r[j] <= fz_degree(j, in_data.angle);
        mu_v_r[j] <= fz_degree(j, in_data.velocity);
      end
    end
  end

  // Stage 2: rules, AND by min, OR by max
  logic [7:0] str_nxt [NUM_SETS];
  logic [7:0] str_r   [NUM_SETS];

  always_comb begin
    logic [7:0] w;
    for (int j = 0; j < NUM_SETS; j++) str_nxt[j] = '0;
    for (int i = 0; i < NUM_RULES; i++) begin
      if (32'(RULES[i].ia) < NUM_SETS && 32'(RULES[i].iv) < NUM_SETS
          && 32'(RULES[i].io) < NUM_SETS) begin
        w = (mu_v_r[RULES[i].iv[2:0]] < mu_a_r[RULES[i].ia[2:0]]) ?
            mu_v_r[RULES[i].iv[2:0]] : mu_a_r[RULES[i].ia[2:0]];
        if (w > str_nxt[RULES[i].io[2:0]]) str_nxt[RULES[i].io[2:0]] = w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) str_r <= str_nxt;
  end

  // Stage 3: clipped trapezoid areas
  logic [AREA_W-1:0] area_r [NUM_SETS];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int j = 0; j < NUM_SETS; j++) area_r[j] <= fz_area(j, str_r[j]);
    end
  end

  // Stage 4: area times centroid
  logic [PROD_W-1:0] prod_r  [NUM_SETS];
  logic [AREA_W-1:0] area2_r [NUM_SETS];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int j = 0; j < NUM_SETS; j++) begin
        prod_r[j]  <= PROD_W'(area_r[j]) * PROD_W'(SET_CTR[j]);
        area2_r[j] <= area_r[j];
      end
    end
  end

  // Stage 5: sums
  logic [SUMP_W-1:0] sump_nxt;
  logic [SUMA_W-1:0] suma_nxt;
  logic [SUMP_W-1:0] sump_r;
  logic [SUMA_W-1:0] suma_r;

  always_comb begin
    sump_nxt = '0;
    suma_nxt = '0;
    for (int j = 0; j < NUM_SETS; j++) begin
      sump_nxt = sump_nxt + SUMP_W'(prod_r[j]);
      suma_nxt = suma_nxt + SUMA_W'(area2_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sump_r <= sump_nxt;
      suma_r <= suma_nxt;
    end
  end

  // Divider: one quotient bit per stage, most significant first
  logic [SUMP_W-1:0] rem_r [QUOT_W];
  logic [SUMA_W-1:0] den_r [QUOT_W];
  logic [QUOT_W-1:0] quo_r [QUOT_W];
  logic              nrf_r [QUOT_W];

  always_ff @(posedge clk) begin
    logic [SUMP_W-1:0] rem_in;
    logic [SUMA_W-1:0] den_in;
    logic [QUOT_W-1:0] quo_in;
    logic              nrf_in;
    logic [SUMP_W-1:0] trial;
    for (int s = 0; s < QUOT_W; s++) begin
      if (s == 0) begin
        rem_in = sump_r;
        den_in = suma_r;
        quo_in = '0;
        nrf_in = (suma_r == '0);
      end else begin
        rem_in = rem_r[s-1];
        den_in = den_r[s-1];
        quo_in = quo_r[s-1];
        nrf_in = nrf_r[s-1];
      end
      trial = SUMP_W'(den_in) << (QUOT_W - 1 - s);
      if (rdy[5+s]) begin
        den_r[s] <= den_in;
        nrf_r[s] <= nrf_in;
        if (rem_in >= trial) begin
          rem_r[s] <= rem_in - trial;
          quo_r[s] <= quo_in | (QUOT_W'(1) << (QUOT_W - 1 - s));
        end else begin
          rem_r[s] <= rem_in;
          quo_r[s] <= quo_in;
        end
      end
    end
  end

  // Output
  assign in_stall               = !rdy[0];
  assign out_valid              = vld_r[NSTG-1];
  assign out_data.no_rule_fired = nrf_r[QUOT_W-1];
  assign out_data.force_res     = nrf_r[QUOT_W-1] ? 8'd0 : quo_r[QUOT_W-1];

  // Checks
  a_nofire_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_rule_fired |-> out_data.force_res == 8'd0)
    else $error("force not zero with no rule fired");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0])
    else $error("input stalled with first stage empty");

  a_force_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.no_rule_fired |-> out_data.force_res <= 8'd223)
    else $error("force beyond highest centroid");

endmodule

`default_nettype wire
